FILE: rtl/core/bf12_pkg.sv
`default_nettype none
package bf12_pkg;

	localparam int MAX_WIDTH        = 1024;
	localparam int MAX_RADIUS       = 4;
	localparam int RANGE_DEPTH      = 4096;
	localparam int WEIGHT_FRAC_BITS = 15;
	localparam int LS_ROWS          = 2 * MAX_RADIUS + 2;
	localparam int LS_DEPTH         = LS_ROWS * MAX_WIDTH;
	localparam int SP_DEPTH         = MAX_RADIUS + 1;

	localparam int PIX_W   = 12;
	localparam int ROW_W   = 12;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int SLOT_W  = $clog2(LS_ROWS);
	localparam int RAD_W   = 3;
	localparam int CFGW_W  = 11;
	localparam int CFGH_W  = 13;
	localparam int WGT_W   = 16;
	localparam int TAPS    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int GS_W    = 2 * WGT_W - WEIGHT_FRAC_BITS;
	localparam int WT_W    = GS_W + WGT_W - WEIGHT_FRAC_BITS;
	localparam int DEN_W   = WT_W + $clog2(TAPS);
	localparam int NUM_W   = DEN_W + PIX_W;
	localparam int CNT_W   = $clog2(NUM_W);

	localparam logic [PIX_W-1:0]  PIX_MAX   = 12'd4095;
	localparam logic [CFGW_W-1:0] W_LIMIT   = 11'd1024;
	localparam logic [CFGH_W-1:0] H_LIMIT   = 13'd4096;
	localparam logic [RAD_W-1:0]  R_LIMIT   = 3'd4;

	typedef enum logic [1:0] {
		CMD_LOAD_RANGE   = 2'd0,
		CMD_LOAD_SPATIAL = 2'd1,
		CMD_PIXEL        = 2'd2,
		CMD_DRAIN        = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [SLOT_W-1:0] slot;
		logic [CFGW_W-1:0] w;
		logic [CFGH_W-1:0] h;
		logic [RAD_W-1:0]  r;
		logic              last;
	} job_t;

	typedef struct packed {
		logic busy;
		logic pending;
	} back_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/bf12_ram.sv
`default_nettype none
module bf12_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/bf12_jobq.sv
`default_nettype none
module bf12_jobq
	import bf12_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire job_t din,
	input  wire logic rd,
	output job_t      dout,
	output logic      not_empty
);
	job_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign dout      = ent_q[rp_q];
	assign not_empty = cnt_q != 2'd0;

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/bf12_front.sv
`default_nettype none
module bf12_front
	import bf12_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [1:0]                command,
	input  wire logic [11:0]               table_index,
	input  wire logic [WGT_W-1:0]          weight,
	input  wire logic [PIX_W-1:0]          pixel,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [12:0]               cfg_data,
	input  wire back_stat_t                stat,
	output logic                           rw_we,
	output logic [$clog2(RANGE_DEPTH)-1:0] rw_waddr,
	output logic                           sp_we,
	output logic [$clog2(SP_DEPTH)-1:0]    sp_waddr,
	output logic [WGT_W-1:0]               wt_wdata,
	output logic                           ls_we,
	output logic [$clog2(LS_DEPTH)-1:0]    ls_waddr,
	output logic [PIX_W-1:0]               ls_wdata,
	output logic                           job_push,
	output job_t                           job
);
	logic [CFGW_W-1:0] width_q;
	logic [CFGH_W-1:0] height_q;
	logic [RAD_W-1:0]  radius_q;
	logic [ROW_W-1:0]  in_row_q, emit_row_q;
	logic [COL_W-1:0]  in_col_q, emit_col_q;
	logic [SLOT_W-1:0] in_slot_q, emit_slot_q;
	logic              done_q;

	logic [CFGW_W-1:0] w_eff;
	logic [CFGH_W-1:0] h_eff, need_r;
	logic [RAD_W-1:0]  r_eff;
	logic [CFGW_W-1:0] need_c;
	logic              accept, pix_take, ready, in_last, emit_last, cfg_hit;
	cmd_t              cmd;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
		cfg_index == REG_RADIUS);
	assign full      = stat.busy || stat.pending;
	assign accept    = push && !full;
	assign cmd       = cmd_t'(command);

	always_comb begin
		w_eff = width_q;
		if (width_q == '0) w_eff = CFGW_W'(1);
		if (width_q > W_LIMIT) w_eff = W_LIMIT;
		h_eff = height_q;
		if (height_q == '0) h_eff = CFGH_W'(1);
		if (height_q > H_LIMIT) h_eff = H_LIMIT;
		r_eff = radius_q > R_LIMIT ? R_LIMIT : radius_q;

		need_r = CFGH_W'(emit_row_q) + CFGH_W'(r_eff);
		if (need_r > h_eff - 1'b1) need_r = h_eff - 1'b1;
		need_c = CFGW_W'(emit_col_q) + CFGW_W'(r_eff);
		if (need_c > w_eff - 1'b1) need_c = w_eff - 1'b1;

		ready     = (CFGH_W'(in_row_q) > need_r) ||
			(CFGH_W'(in_row_q) == need_r && CFGW_W'(in_col_q) >= need_c);
		in_last   = CFGH_W'(in_row_q) == h_eff - 1'b1 && CFGW_W'(in_col_q) == w_eff - 1'b1;
		emit_last = CFGH_W'(emit_row_q) == h_eff - 1'b1 &&
			CFGW_W'(emit_col_q) == w_eff - 1'b1;
	end

	assign pix_take = accept && cmd == CMD_PIXEL && !done_q;
	assign job_push = (pix_take && ready) || (accept && cmd == CMD_DRAIN && done_q);

	assign rw_we    = accept && cmd == CMD_LOAD_RANGE;
	assign rw_waddr = table_index;
	assign sp_we    = accept && cmd == CMD_LOAD_SPATIAL && table_index <= 12'(MAX_RADIUS);
	assign sp_waddr = table_index[$clog2(SP_DEPTH)-1:0];
	assign wt_wdata = weight;
	assign ls_we    = pix_take;
	assign ls_waddr = {in_slot_q, in_col_q};
	assign ls_wdata = pixel;

	assign job.row  = emit_row_q;
	assign job.col  = emit_col_q;
	assign job.slot = emit_slot_q;
	assign job.w    = w_eff;
	assign job.h    = h_eff;
	assign job.r    = r_eff;
	assign job.last = emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= W_LIMIT;
			height_q    <= 13'd1024;
			radius_q    <= 3'd2;
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_slot_q   <= '0;
			emit_row_q  <= '0;
			emit_col_q  <= '0;
			emit_slot_q <= '0;
			done_q      <= 1'b0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[CFGW_W-1:0];
				REG_HEIGHT: height_q <= cfg_data;
				default:    radius_q <= cfg_data[RAD_W-1:0];
			endcase
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_slot_q   <= '0;
			emit_row_q  <= '0;
			emit_col_q  <= '0;
			emit_slot_q <= '0;
			done_q      <= 1'b0;
		end else if (job_push && emit_last) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_slot_q   <= '0;
			emit_row_q  <= '0;
			emit_col_q  <= '0;
			emit_slot_q <= '0;
			done_q      <= 1'b0;
		end else begin
			if (pix_take) begin
				if (in_last) begin
					done_q <= 1'b1;
				end else if (CFGW_W'(in_col_q) == w_eff - 1'b1) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 1'b1;
					in_slot_q <= in_slot_q == SLOT_W'(LS_ROWS - 1) ? '0 : in_slot_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (job_push) begin
				if (CFGW_W'(emit_col_q) == w_eff - 1'b1) begin
					emit_col_q  <= '0;
					emit_row_q  <= emit_row_q + 1'b1;
					emit_slot_q <= emit_slot_q == SLOT_W'(LS_ROWS - 1) ? '0 :
						emit_slot_q + 1'b1;
				end else begin
					emit_col_q <= emit_col_q + 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/bf12_back.sv
`default_nettype none
module bf12_back
	import bf12_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      job_valid,
	input  wire job_t                      job,
	output logic                           job_pop,
	output logic                           busy,
	output logic [$clog2(LS_DEPTH)-1:0]    ls_raddr,
	input  wire logic [PIX_W-1:0]          ls_rdata,
	output logic [$clog2(SP_DEPTH)-1:0]    sp_raddr_a,
	input  wire logic [WGT_W-1:0]          sp_rdata_a,
	output logic [$clog2(SP_DEPTH)-1:0]    sp_raddr_b,
	input  wire logic [WGT_W-1:0]          sp_rdata_b,
	output logic [$clog2(RANGE_DEPTH)-1:0] rw_raddr,
	input  wire logic [WGT_W-1:0]          rw_rdata,
	input  wire logic                      pop,
	output logic                           empty,
	output logic [PIX_W-1:0]               out_pixel,
	output logic [ROW_W-1:0]               out_row,
	output logic [9:0]                     out_col,
	output logic                           frame_last
);
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CENTRE = 6'b000010,
		ST_TAPS   = 6'b000100,
		ST_FLUSH  = 6'b001000,
		ST_DIVIDE = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic              first_q;
	logic signed [4:0] k_q, l_q;
	logic [SLOT_W-1:0] slotk_q;
	logic [PIX_W-1:0]  centre_q;

	logic              v_s1, ok_s1, v_s2, ok_s2, v_s3, v_s4;
	logic [GS_W-1:0]   gs_s2;
	logic [PIX_W-1:0]  pix_s2, pix_s3;
	logic [WT_W-1:0]   wt_s3, wt_s4;
	logic [PIX_W+WT_W-1:0] pw_s4;

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    rem_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic              den_zero_q;
	logic              out_valid_q;

	logic signed [13:0] y;
	logic signed [11:0] x;
	logic               in_img, last_tap, load_out;
	logic signed [4:0]  r_s, ak, al;
	logic [PIX_W-1:0]   centre, diff;
	logic [2*WGT_W-1:0] gs_full;
	logic [GS_W+WGT_W-1:0] wt_full;
	logic [DEN_W:0]     trial;
	logic [SLOT_W-1:0]  slot_start;

	assign busy    = state_q != ST_IDLE;
	assign job_pop = state_q == ST_IDLE && job_valid;
	assign empty   = !out_valid_q;
	assign load_out = state_q == ST_FINISH && (!out_valid_q || pop);

	always_comb begin
		r_s      = 5'(job_q.r);
		y        = $signed({2'b00, job_q.row}) + 14'(k_q);
		x        = $signed({2'b00, job_q.col}) + 12'(l_q);
		in_img   = y >= 0 && y < $signed({1'b0, job_q.h}) &&
			x >= 0 && x < $signed({1'b0, job_q.w});
		last_tap = k_q == r_s && l_q == r_s;
		ak       = k_q < 0 ? -k_q : k_q;
		al       = l_q < 0 ? -l_q : l_q;
		ls_raddr = state_q == ST_CENTRE ? {job_q.slot, job_q.col} :
			{slotk_q, x[COL_W-1:0]};
		sp_raddr_a = ak[$clog2(SP_DEPTH)-1:0];
		sp_raddr_b = al[$clog2(SP_DEPTH)-1:0];
		// first tap cycle still holds the centre read
		centre   = first_q ? ls_rdata : centre_q;
		diff     = ls_rdata >= centre ? ls_rdata - centre : centre - ls_rdata;
		rw_raddr = diff;
		gs_full  = sp_rdata_a * sp_rdata_b;
		wt_full  = gs_s2 * rw_rdata;
		trial    = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
		slot_start = job_q.slot >= SLOT_W'(job_q.r) ? job_q.slot - SLOT_W'(job_q.r) :
			job_q.slot + SLOT_W'(LS_ROWS) - SLOT_W'(job_q.r);
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (first_q) begin
			centre_q <= ls_rdata;
		end
		gs_s2  <= gs_full[2*WGT_W-1:WEIGHT_FRAC_BITS];
		pix_s2 <= ls_rdata;
		// taps outside the image may land on lines never written
		pix_s3 <= ok_s2 ? pix_s2 : '0;
		wt_s3  <= ok_s2 ? wt_full[GS_W+WGT_W-1:WEIGHT_FRAC_BITS] : '0;
		wt_s4  <= wt_s3;
		pw_s4  <= pix_s3 * wt_s3;
		if (load_out) begin
			out_row    <= job_q.row;
			out_col    <= 10'(job_q.col);
			frame_last <= job_q.last;
			if (den_zero_q) begin
				out_pixel <= '0;
			end else if (num_q > NUM_W'(PIX_MAX)) begin
				out_pixel <= PIX_MAX;
			end else begin
				out_pixel <= num_q[PIX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b0;
			k_q         <= '0;
			l_q         <= '0;
			slotk_q     <= '0;
			v_s1        <= 1'b0;
			ok_s1       <= 1'b0;
			v_s2        <= 1'b0;
			ok_s2       <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			num_q       <= '0;
			den_q       <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
			den_zero_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			first_q <= 1'b0;
			v_s1    <= 1'b0;
			ok_s1   <= 1'b0;
			v_s2    <= v_s1;
			ok_s2   <= ok_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			if (v_s4) begin
				num_q <= num_q + NUM_W'(pw_s4);
				den_q <= den_q + DEN_W'(wt_s4);
			end
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_CENTRE;
					end
				end
				ST_CENTRE: begin
					k_q     <= -5'(job_q.r);
					l_q     <= -5'(job_q.r);
					slotk_q <= slot_start;
					num_q   <= '0;
					den_q   <= '0;
					first_q <= 1'b1;
					state_q <= ST_TAPS;
				end
				ST_TAPS: begin
					v_s1  <= 1'b1;
					ok_s1 <= in_img;
					if (last_tap) begin
						state_q <= ST_FLUSH;
					end else if (l_q == r_s) begin
						l_q     <= -r_s;
						k_q     <= k_q + 5'sd1;
						slotk_q <= slotk_q == SLOT_W'(LS_ROWS - 1) ? '0 : slotk_q + 1'b1;
					end else begin
						l_q <= l_q + 5'sd1;
					end
				end
				ST_FLUSH: begin
					if (!v_s1 && !v_s2 && !v_s3 && !v_s4) begin
						rem_q      <= '0;
						div_cnt_q  <= CNT_W'(NUM_W - 1);
						den_zero_q <= den_q == '0;
						state_q    <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					// restoring division, one quotient bit per cycle
					if (trial >= {1'b0, den_q}) begin
						rem_q <= trial - {1'b0, den_q};
						num_q <= {num_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						num_q <= {num_q[NUM_W-2:0], 1'b0};
					end
					if (div_cnt_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !(v_s1 || v_s2 || v_s3 || v_s4))
		else $error("tap pipeline busy while idle");
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && state_q == ST_IDLE)
		else $error("finished result not loaded");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE && !den_zero_q) |-> rem_q < {1'b0, den_q})
		else $error("divider remainder out of range");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> state_q == ST_CENTRE)
		else $error("job taken without starting");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/bilateral_filter_12bit_top.sv
`default_nettype none
// Channel  Handshake                Payload
// input    push / full              command, table_index, weight, pixel
// result   pop / empty              out_pixel, out_row, out_col, frame_last
// config   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A request that emits a pixel runs one tap per cycle through the shared multiply
// pipe, then a one-bit-per-cycle divider. full stays high while a job is queued,
// computing or waiting for the output register.
// A finished result waits in the output register; the next request is taken
// meanwhile. Reset is asynchronous, active low; memories hold no reset.
module bilateral_filter_12bit_top
	import bf12_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         command,
	input  wire logic [11:0]        table_index,
	input  wire logic [WGT_W-1:0]   weight,
	input  wire logic [PIX_W-1:0]   pixel,
	input  wire logic               pop,
	output logic                    empty,
	output logic [PIX_W-1:0]        out_pixel,
	output logic [ROW_W-1:0]        out_row,
	output logic [9:0]              out_col,
	output logic                    frame_last,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [12:0]        cfg_data
);
	back_stat_t                     stat;
	logic                           rw_we, sp_we, ls_we, job_push, job_pop, q_ne, back_busy;
	logic [$clog2(RANGE_DEPTH)-1:0] rw_waddr, rw_raddr;
	logic [$clog2(SP_DEPTH)-1:0]    sp_waddr, sp_raddr_a, sp_raddr_b;
	logic [WGT_W-1:0]               wt_wdata, rw_rdata, sp_rdata_a, sp_rdata_b;
	logic [$clog2(LS_DEPTH)-1:0]    ls_waddr, ls_raddr;
	logic [PIX_W-1:0]               ls_wdata, ls_rdata;
	job_t                           job_in, job_out;

	assign stat.busy    = back_busy;
	assign stat.pending = q_ne;

	bf12_front u_front (
		.clk, .arst_n, .push, .full, .command, .table_index, .weight, .pixel,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .stat,
		.rw_we, .rw_waddr, .sp_we, .sp_waddr, .wt_wdata,
		.ls_we, .ls_waddr, .ls_wdata, .job_push, .job(job_in)
	);

	bf12_jobq u_jobq (
		.clk, .arst_n, .wr(job_push), .din(job_in), .rd(job_pop), .dout(job_out),
		.not_empty(q_ne)
	);

	bf12_ram #(.WIDTH(WGT_W), .DEPTH(RANGE_DEPTH)) u_range (
		.clk, .we(rw_we), .waddr(rw_waddr), .wdata(wt_wdata), .raddr(rw_raddr),
		.rdata(rw_rdata)
	);

	bf12_ram #(.WIDTH(WGT_W), .DEPTH(SP_DEPTH)) u_spatial_a (
		.clk, .we(sp_we), .waddr(sp_waddr), .wdata(wt_wdata), .raddr(sp_raddr_a),
		.rdata(sp_rdata_a)
	);

	bf12_ram #(.WIDTH(WGT_W), .DEPTH(SP_DEPTH)) u_spatial_b (
		.clk, .we(sp_we), .waddr(sp_waddr), .wdata(wt_wdata), .raddr(sp_raddr_b),
		.rdata(sp_rdata_b)
	);

	bf12_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_lines (
		.clk, .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata), .raddr(ls_raddr),
		.rdata(ls_rdata)
	);

	bf12_back u_back (
		.clk, .arst_n, .job_valid(q_ne), .job(job_out), .job_pop, .busy(back_busy),
		.ls_raddr, .ls_rdata, .sp_raddr_a, .sp_rdata_a, .sp_raddr_b, .sp_rdata_b,
		.rw_raddr, .rw_rdata, .pop, .empty, .out_pixel, .out_row, .out_col, .frame_last
	);
endmodule
`default_nettype wire
